FILE: design/hcmb_pkg.sv
package hcmb_pkg;

  // Default sizes of the stored regions.
  localparam int VIDEO_BYTES_DEF  = 8192;
  localparam int WORK_BYTES_DEF   = 8192;
  localparam int OBJECT_BYTES_DEF = 160;
  localparam int HIGH_BYTES_DEF   = 127;

  // Widths of the bus fields and of a store offset.
  localparam int OP_W   = 2;
  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;
  localparam int OFF_W  = 13;
  localparam int BOOT_AW = 8;

  // Memory map boundaries.
  localparam logic [ADDR_W-1:0] ADDR_BOOT_END = 16'h0100;
  localparam logic [ADDR_W-1:0] ADDR_VIDEO    = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_CART_RAM = 16'hA000;
  localparam logic [ADDR_W-1:0] ADDR_WORK     = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_OBJECT   = 16'hFE00;
  localparam logic [ADDR_W-1:0] ADDR_UNUSABLE = 16'hFEA0;
  localparam logic [ADDR_W-1:0] ADDR_IO       = 16'hFF00;
  localparam logic [ADDR_W-1:0] ADDR_BOOT_OFF = 16'hFF50;
  localparam logic [ADDR_W-1:0] ADDR_HIGH     = 16'hFF80;
  localparam logic [ADDR_W-1:0] ADDR_IRQ      = 16'hFFFF;

  // Fixed read values.
  localparam logic [DATA_W-1:0] JOYPAD_IDLE = 8'hCF;
  localparam logic [DATA_W-1:0] OPEN_BUS    = 8'hFF;

  // Limit type for comparing an offset against a region size.
  typedef logic [OFF_W:0] lim_t;

  // Bus operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2
  } op_t;

  // Store selected by an access.
  typedef enum logic [2:0] {
    SEL_CONST,
    SEL_BOOT,
    SEL_VIDEO,
    SEL_WORK,
    SEL_OBJECT,
    SEL_HIGH,
    SEL_IRQ
  } sel_t;

  // One decoded access, passed from the decoder to the store.
  typedef struct packed {
    sel_t              sel;
    logic              wr;
    logic              unmap;
    logic              cart;
    logic [DATA_W-1:0] cval;
    logic [DATA_W-1:0] data;
    logic [OFF_W-1:0]  off;
  } acc_t;

endpackage

FILE: design/hcmb_ram.sv
module hcmb_ram import hcmb_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/hcmb_decode.sv
module hcmb_decode import hcmb_pkg::*; #(
  parameter int VIDEO_BYTES  = VIDEO_BYTES_DEF,
  parameter int WORK_BYTES   = WORK_BYTES_DEF,
  parameter int OBJECT_BYTES = OBJECT_BYTES_DEF,
  parameter int HIGH_BYTES   = HIGH_BYTES_DEF
) (
  input  logic [OP_W-1:0]   opcode,
  input  logic [ADDR_W-1:0] address,
  input  logic [DATA_W-1:0] write_data,
  input  logic              boot_mapped,
  output acc_t              acc
);

  localparam lim_t VIDEO_LIM  = lim_t'(VIDEO_BYTES);
  localparam lim_t WORK_LIM   = lim_t'(WORK_BYTES);
  localparam lim_t OBJECT_LIM = lim_t'(OBJECT_BYTES);
  localparam lim_t HIGH_LIM   = lim_t'(HIGH_BYTES);

  logic             is_cart;
  logic             is_io;
  logic             is_boot;
  sel_t             loc_sel;
  logic [OFF_W-1:0] loc_off;

  // Region flags shared by reads and writes.
  assign is_cart = (address < ADDR_VIDEO) ||
                   ((address >= ADDR_CART_RAM) && (address < ADDR_WORK));
  assign is_io   = (address >= ADDR_IO) && (address < ADDR_HIGH);
  assign is_boot = (address < ADDR_BOOT_END);

  // Locate the stored byte; the work RAM and its echo share the low 13 address bits.
  always_comb begin
    loc_sel = SEL_CONST;
    loc_off = '0;
    if ((address >= ADDR_VIDEO) && (address < ADDR_CART_RAM)) begin
      loc_off = address[OFF_W-1:0];
      if ({1'b0, loc_off} < VIDEO_LIM) loc_sel = SEL_VIDEO;
    end else if ((address >= ADDR_WORK) && (address < ADDR_OBJECT)) begin
      loc_off = address[OFF_W-1:0];
      if ({1'b0, loc_off} < WORK_LIM) loc_sel = SEL_WORK;
    end else if ((address >= ADDR_OBJECT) && (address < ADDR_UNUSABLE)) begin
      loc_off = {{(OFF_W-8){1'b0}}, address[7:0]};
      if ({1'b0, loc_off} < OBJECT_LIM) loc_sel = SEL_OBJECT;
    end else if ((address >= ADDR_HIGH) && (address < ADDR_IRQ)) begin
      loc_off = {{(OFF_W-7){1'b0}}, address[6:0]};
      if ({1'b0, loc_off} < HIGH_LIM) loc_sel = SEL_HIGH;
    end else if (address == ADDR_IRQ) begin
      loc_sel = SEL_IRQ;
    end
  end

  // Build the access from the operation code.
  always_comb begin
    acc       = '0;
    acc.sel   = SEL_CONST;
    acc.data  = write_data;
    unique case (op_t'(opcode))
      OP_READ: begin
        if (boot_mapped && is_boot) begin
          acc.sel = SEL_BOOT;
          acc.off = {{(OFF_W-BOOT_AW){1'b0}}, address[BOOT_AW-1:0]};
        end else if (is_cart) begin
          acc.cval = OPEN_BUS;
          acc.cart = 1'b1;
        end else if (is_io) begin
          acc.cval = (address == ADDR_IO) ? JOYPAD_IDLE : OPEN_BUS;
        end else begin
          acc.sel  = loc_sel;
          acc.off  = loc_off;
          acc.cval = OPEN_BUS;
        end
      end
      OP_WRITE: begin
        acc.wr = 1'b1;
        if (is_cart) begin
          acc.cart = 1'b1;
        end else if (is_io) begin
          acc.unmap = (address == ADDR_BOOT_OFF) && (write_data != '0);
        end else begin
          acc.sel = loc_sel;
          acc.off = loc_off;
        end
      end
      OP_LOAD: begin
        acc.wr = 1'b1;
        if (is_boot) begin
          acc.sel = SEL_BOOT;
          acc.off = {{(OFF_W-BOOT_AW){1'b0}}, address[BOOT_AW-1:0]};
        end
      end
      default: begin
        acc.sel = SEL_CONST;
      end
    endcase
  end

endmodule

FILE: design/hcmb_store.sv
module hcmb_store import hcmb_pkg::*; #(
  parameter int VIDEO_BYTES  = VIDEO_BYTES_DEF,
  parameter int WORK_BYTES   = WORK_BYTES_DEF,
  parameter int OBJECT_BYTES = OBJECT_BYTES_DEF,
  parameter int HIGH_BYTES   = HIGH_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  acc_t              acc,
  input  logic              acc_en,
  output logic              busy,
  output logic              boot_mapped,
  output logic [DATA_W-1:0] rdata
);

  localparam int VIDEO_AW  = (VIDEO_BYTES > 1) ? $clog2(VIDEO_BYTES) : 1;
  localparam int WORK_AW   = (WORK_BYTES > 1) ? $clog2(WORK_BYTES) : 1;
  localparam int OBJECT_AW = (OBJECT_BYTES > 1) ? $clog2(OBJECT_BYTES) : 1;
  localparam int HIGH_AW   = (HIGH_BYTES > 1) ? $clog2(HIGH_BYTES) : 1;
  localparam int MAX_A     = (VIDEO_BYTES > WORK_BYTES) ? VIDEO_BYTES : WORK_BYTES;
  localparam int MAX_B     = (OBJECT_BYTES > HIGH_BYTES) ? OBJECT_BYTES : HIGH_BYTES;
  localparam int CLR_DEPTH = (MAX_A > MAX_B) ? MAX_A : MAX_B;
  localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

  localparam logic [CLR_W:0]   VIDEO_CLR  = (CLR_W+1)'(VIDEO_BYTES);
  localparam logic [CLR_W:0]   WORK_CLR   = (CLR_W+1)'(WORK_BYTES);
  localparam logic [CLR_W:0]   OBJECT_CLR = (CLR_W+1)'(OBJECT_BYTES);
  localparam logic [CLR_W:0]   HIGH_CLR   = (CLR_W+1)'(HIGH_BYTES);
  localparam logic [CLR_W-1:0] CLR_LAST   = CLR_W'(CLR_DEPTH - 1);

  logic [CLR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              boot_mapped_r, boot_mapped_nxt;
  logic [DATA_W-1:0] irq_r, irq_nxt;
  logic [DATA_W-1:0] irq_rd_r;
  sel_t              sel_r;
  logic              wr_r;
  logic [DATA_W-1:0] cval_r;

  logic              write_now;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] video_rd, work_rd, object_rd, high_rd, boot_rd;

  // Clearing pass over the region stores (not the boot image) after reset, one entry per cycle.
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    busy_nxt    = busy_r;
    if (busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == CLR_LAST) busy_nxt = 1'b0;
    end
  end

  // Boot mapping and interrupt enable byte.
  always_comb begin
    boot_mapped_nxt = boot_mapped_r;
    irq_nxt         = irq_r;
    if (acc_en && acc.unmap) boot_mapped_nxt = 1'b0;
    if (acc_en && acc.wr && (acc.sel == SEL_IRQ)) irq_nxt = acc.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r     <= '0;
      busy_r        <= 1'b1;
      boot_mapped_r <= 1'b1;
      irq_r         <= '0;
    end else begin
      clr_cnt_r     <= clr_cnt_nxt;
      busy_r        <= busy_nxt;
      boot_mapped_r <= boot_mapped_nxt;
      irq_r         <= irq_nxt;
    end
  end

  // Result selection travels alongside the memory read.
  always_ff @(posedge clk) begin
    if (acc_en) begin
      sel_r    <= acc.sel;
      wr_r     <= acc.wr;
      cval_r   <= acc.cval;
      irq_rd_r <= irq_r;
    end
  end

  assign write_now = acc_en && acc.wr;
  assign mem_wdata = busy_r ? '0 : acc.data;

  hcmb_ram #(.DEPTH(VIDEO_BYTES), .AW(VIDEO_AW)) u_video (
    .clk   (clk),
    .we    (busy_r ? ({1'b0, clr_cnt_r} < VIDEO_CLR) : (write_now && acc.sel == SEL_VIDEO)),
    .waddr (busy_r ? clr_cnt_r[VIDEO_AW-1:0] : acc.off[VIDEO_AW-1:0]),
    .wdata (mem_wdata),
    .re    (acc_en),
    .raddr (acc.off[VIDEO_AW-1:0]),
    .rdata (video_rd)
  );

  hcmb_ram #(.DEPTH(WORK_BYTES), .AW(WORK_AW)) u_work (
    .clk   (clk),
    .we    (busy_r ? ({1'b0, clr_cnt_r} < WORK_CLR) : (write_now && acc.sel == SEL_WORK)),
    .waddr (busy_r ? clr_cnt_r[WORK_AW-1:0] : acc.off[WORK_AW-1:0]),
    .wdata (mem_wdata),
    .re    (acc_en),
    .raddr (acc.off[WORK_AW-1:0]),
    .rdata (work_rd)
  );

  hcmb_ram #(.DEPTH(OBJECT_BYTES), .AW(OBJECT_AW)) u_object (
    .clk   (clk),
    .we    (busy_r ? ({1'b0, clr_cnt_r} < OBJECT_CLR) :
                     (write_now && acc.sel == SEL_OBJECT)),
    .waddr (busy_r ? clr_cnt_r[OBJECT_AW-1:0] : acc.off[OBJECT_AW-1:0]),
    .wdata (mem_wdata),
    .re    (acc_en),
    .raddr (acc.off[OBJECT_AW-1:0]),
    .rdata (object_rd)
  );

  hcmb_ram #(.DEPTH(HIGH_BYTES), .AW(HIGH_AW)) u_high (
    .clk   (clk),
    .we    (busy_r ? ({1'b0, clr_cnt_r} < HIGH_CLR) : (write_now && acc.sel == SEL_HIGH)),
    .waddr (busy_r ? clr_cnt_r[HIGH_AW-1:0] : acc.off[HIGH_AW-1:0]),
    .wdata (mem_wdata),
    .re    (acc_en),
    .raddr (acc.off[HIGH_AW-1:0]),
    .rdata (high_rd)
  );

  // The user must read the boot image only after loading it; the block itself does not enforce this.
  hcmb_ram #(.DEPTH(1 << BOOT_AW), .AW(BOOT_AW)) u_boot (
    .clk   (clk),
    .we    (write_now && acc.sel == SEL_BOOT),
    .waddr (acc.off[BOOT_AW-1:0]),
    .wdata (acc.data),
    .re    (acc_en),
    .raddr (acc.off[BOOT_AW-1:0]),
    .rdata (boot_rd)
  );

  // Writes and loads return zero; reads take the selected source.
  always_comb begin
    rdata = '0;
    if (!wr_r) begin
      unique case (sel_r)
        SEL_CONST:  rdata = cval_r;
        SEL_BOOT:   rdata = boot_rd;
        SEL_VIDEO:  rdata = video_rd;
        SEL_WORK:   rdata = work_rd;
        SEL_OBJECT: rdata = object_rd;
        SEL_HIGH:   rdata = high_rd;
        SEL_IRQ:    rdata = irq_rd_r;
        default:    rdata = '0;
      endcase
    end
  end

  assign busy        = busy_r;
  assign boot_mapped = boot_mapped_r;

endmodule

FILE: design/handheld_console_memory_bus_decoder_top.sv
// Memory bus decoder for a handheld console memory map.
// Input channel in_*: one bus access per word (read, write or boot image
// load). Output channel out_*: exactly one result word per access, in order,
// carrying the byte read (zero for writes and loads) and a cartridge flag.
// Video RAM, work RAM, object RAM, high RAM and the boot image sit in
// synchronous memories with a registered read port; a write or load writes
// its memory at acceptance, and every access has its read data registered on
// the same edge. From acceptance, the result passes through the read stage
// and the output register to out_tvalid. One access is taken per cycle while
// the output side keeps up. After reset the block clears its region memories
// (not the boot image), one entry per cycle, through as many entries as the
// largest of the four region sizes (8192 with the defaults); in_tready stays
// low throughout. The boot image is mapped after reset.
// When the receiver stalls, the result stays in the output register and one
// further access may be held in the read stage; after that in_tready drops.
module handheld_console_memory_bus_decoder_top import hcmb_pkg::*; #(
  parameter int VIDEO_BYTES  = VIDEO_BYTES_DEF,
  parameter int WORK_BYTES   = WORK_BYTES_DEF,
  parameter int OBJECT_BYTES = OBJECT_BYTES_DEF,
  parameter int HIGH_BYTES   = HIGH_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [1:0] opcode, [17:2] address, [25:18] write_data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] read_data
  output logic        out_tuser   // [0] cart_region
);

  acc_t              acc;
  logic              acc_en;
  logic              busy;
  logic              boot_mapped;
  logic [DATA_W-1:0] s1_data;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_cart_r;
  logic              s1_adv;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r;
  logic              out_cart_r;

  hcmb_decode #(
    .VIDEO_BYTES (VIDEO_BYTES),
    .WORK_BYTES  (WORK_BYTES),
    .OBJECT_BYTES(OBJECT_BYTES),
    .HIGH_BYTES  (HIGH_BYTES)
  ) u_decode (
    .opcode     (in_tdata[1:0]),
    .address    (in_tdata[17:2]),
    .write_data (in_tdata[25:18]),
    .boot_mapped(boot_mapped),
    .acc        (acc)
  );

  hcmb_store #(
    .VIDEO_BYTES (VIDEO_BYTES),
    .WORK_BYTES  (WORK_BYTES),
    .OBJECT_BYTES(OBJECT_BYTES),
    .HIGH_BYTES  (HIGH_BYTES)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .acc_en     (acc_en),
    .busy       (busy),
    .boot_mapped(boot_mapped),
    .rdata      (s1_data)
  );

  // Handshake: the read stage moves on whenever the output register frees up.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !busy && (!s1_valid_r || s1_adv);
  assign acc_en    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      s1_valid_nxt  = 1'b0;
    end
    if (acc_en) s1_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers of the read stage and the output word.
  always_ff @(posedge clk) begin
    if (acc_en) begin
      s1_cart_r <= acc.cart;
    end
    if (s1_adv) begin
      out_data_r <= s1_data;
      out_cart_r <= s1_cart_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_cart_r;

endmodule

FILE: design/hcmb_checker.sv
module hcmb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser
);

  // Straight after reset the block is clearing and has nothing to show.
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> (!out_tvalid && !in_tready))
    else $error("block not quiet after reset");

  // A stalled result word holds its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result word changed");

  // Cartridge accesses read open bus or, for writes, zero.
  a_cart_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> ((out_tdata == 8'hFF) || (out_tdata == 8'h00)))
    else $error("cartridge word carries unexpected data");

endmodule

bind handheld_console_memory_bus_decoder_top hcmb_checker u_hcmb_checker (.*);
